// ----- hw/rtl/tgr_pkg.sv -----
// Shared constants, job type and glyph font for the text glyph renderer.
`default_nettype none
package tgr_pkg;

  localparam int unsigned SCREEN_COLUMNS = 128;
  localparam int unsigned SCREEN_PAGES   = 8;
  localparam int unsigned GLYPH_WIDTH    = 6;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // cursor limits
  localparam logic [7:0] COL_LIMIT  = 8'(SCREEN_COLUMNS - GLYPH_WIDTH);
  localparam logic [7:0] PAGE_LIMIT = 8'(SCREEN_PAGES);
  localparam logic [7:0] GLYPH_ADV  = 8'(GLYPH_WIDTH);
  localparam logic [7:0] PAGE_MAX   = 8'hFF;

  // printable range
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7E;

  // controller commands
  localparam logic [7:0] CMD_PAGE_ADDR = 8'hB0;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;

  // byte sequence of one character
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_PAGE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_COL_LO = 4'd1;
  localparam logic [STEP_W-1:0] STEP_COL_HI = 4'd2;
  localparam logic [STEP_W-1:0] STEP_GLYPH0 = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;

  typedef struct packed {
    logic [2:0] page;
    logic [7:0] col;
    logic [6:0] glyph;
  } tgr_job_t;

  // Five glyph columns, first column in the top byte; the sixth is always blank.
  function automatic logic [39:0] glyph_row(input logic [6:0] g);
    logic [39:0] row;
    case (g)
      7'd0:  row = 40'h0000000000;
      7'd1:  row = 40'h00005F0000;
      7'd2:  row = 40'h0007000700;
      7'd3:  row = 40'h147F147F14;
      7'd4:  row = 40'h242A7F2A12;
      7'd5:  row = 40'h2313086462;
      7'd6:  row = 40'h3649552250;
      7'd7:  row = 40'h0005030000;
      7'd8:  row = 40'h001C224100;
      7'd9:  row = 40'h0041221C00;
      7'd10: row = 40'h082A1C2A08;
      7'd11: row = 40'h08083E0808;
      7'd12: row = 40'h0050300000;
      7'd13: row = 40'h0808080808;
      7'd14: row = 40'h0060600000;
      7'd15: row = 40'h2010080402;
      7'd16: row = 40'h3E5149453E;
      7'd17: row = 40'h00427F4000;
      7'd18: row = 40'h4261514946;
      7'd19: row = 40'h2141454B31;
      7'd20: row = 40'h1814127F10;
      7'd21: row = 40'h2745454539;
      7'd22: row = 40'h3C4A494930;
      7'd23: row = 40'h0171090503;
      7'd24: row = 40'h3649494936;
      7'd25: row = 40'h064949291E;
      7'd26: row = 40'h0036360000;
      7'd27: row = 40'h0056360000;
      7'd28: row = 40'h0008142241;
      7'd29: row = 40'h1414141414;
      7'd30: row = 40'h0041221408;
      7'd31: row = 40'h0201510906;
      7'd32: row = 40'h324979413E;
      7'd33: row = 40'h7E1111117E;
      7'd34: row = 40'h7F49494936;
      7'd35: row = 40'h3E41414122;
      7'd36: row = 40'h7F4141221C;
      7'd37: row = 40'h7F49494941;
      7'd38: row = 40'h7F09090101;
      7'd39: row = 40'h3E41415132;
      7'd40: row = 40'h7F0808087F;
      7'd41: row = 40'h00417F4100;
      7'd42: row = 40'h2040413F01;
      7'd43: row = 40'h7F08142241;
      7'd44: row = 40'h7F40404040;
      7'd45: row = 40'h7F0204027F;
      7'd46: row = 40'h7F0408107F;
      7'd47: row = 40'h3E4141413E;
      7'd48: row = 40'h7F09090906;
      7'd49: row = 40'h3E4151215E;
      7'd50: row = 40'h7F09192946;
      7'd51: row = 40'h4649494931;
      7'd52: row = 40'h01017F0101;
      7'd53: row = 40'h3F4040403F;
      7'd54: row = 40'h1F2040201F;
      7'd55: row = 40'h7F2018207F;
      7'd56: row = 40'h6314081463;
      7'd57: row = 40'h0304780403;
      7'd58: row = 40'h6151494543;
      7'd59: row = 40'h00007F4141;
      7'd60: row = 40'h0204081020;
      7'd61: row = 40'h41417F0000;
      7'd62: row = 40'h0402010204;
      7'd63: row = 40'h4040404040;
      7'd64: row = 40'h0001020400;
      7'd65: row = 40'h2054545478;
      7'd66: row = 40'h7F48444438;
      7'd67: row = 40'h3844444420;
      7'd68: row = 40'h384444487F;
      7'd69: row = 40'h3854545418;
      7'd70: row = 40'h087E090102;
      7'd71: row = 40'h085454543C;
      7'd72: row = 40'h7F08040478;
      7'd73: row = 40'h00447D4000;
      7'd74: row = 40'h2040443D00;
      7'd75: row = 40'h007F102844;
      7'd76: row = 40'h00417F4000;
      7'd77: row = 40'h7C04180478;
      7'd78: row = 40'h7C08040478;
      7'd79: row = 40'h3844444438;
      7'd80: row = 40'h7C14141408;
      7'd81: row = 40'h081414187C;
      7'd82: row = 40'h7C08040408;
      7'd83: row = 40'h4854545420;
      7'd84: row = 40'h043F444020;
      7'd85: row = 40'h3C4040207C;
      7'd86: row = 40'h1C2040201C;
      7'd87: row = 40'h3C4030403C;
      7'd88: row = 40'h4428102844;
      7'd89: row = 40'h0C5050503C;
      7'd90: row = 40'h4464544C44;
      7'd91: row = 40'h0008364100;
      7'd92: row = 40'h00007F0000;
      7'd93: row = 40'h0041360800;
      7'd94: row = 40'h0804081008;
      default: row = 40'h0000000000;
    endcase
    return row;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tgr_if.sv -----
// Valid/ready channel interfaces for characters in and display bytes out.
`default_nettype none
interface tgr_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_text;
  logic [7:0] start_col;
  logic [7:0] start_page;
  logic [7:0] char_code;

  modport source (output valid, output start_of_text, output start_col,
                  output start_page, output char_code, input ready);
  modport sink   (input valid, input start_of_text, input start_col,
                  input start_page, input char_code, output ready);
endinterface

interface tgr_out_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] out_byte;
  logic       last_of_char;

  modport source (output valid, output is_data, output out_byte,
                  output last_of_char, input ready);
  modport sink   (input valid, input is_data, input out_byte,
                  input last_of_char, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tgr_front.sv -----
// Front end: takes characters, keeps the cursor and queues drawable jobs.
`default_nettype none
module tgr_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tgr_in_if.sink          in_if,
  input  wire logic       q_full_i,
  output tgr_pkg::tgr_job_t q_job_o,
  output logic            q_push_o
);
  import tgr_pkg::*;

  logic [7:0] col_q, col_d;
  logic [7:0] page_q, page_d;
  logic       stop_q, stop_d;

  logic       xfer;
  logic [7:0] col_ld, page_ld, col_w, page_w;
  logic       stop_ld, wrap, past, draw, printable;
  logic [7:0] code_adj;

  assign in_if.ready = !q_full_i;
  assign xfer        = in_if.valid && in_if.ready;

  always_comb begin
    col_ld  = in_if.start_of_text ? in_if.start_col  : col_q;
    page_ld = in_if.start_of_text ? in_if.start_page : page_q;
    stop_ld = in_if.start_of_text ? 1'b0 : stop_q;

    wrap   = col_ld > COL_LIMIT;
    col_w  = wrap ? 8'h00 : col_ld;
    page_w = page_ld;
    if (wrap && page_ld != PAGE_MAX) begin
      page_w = page_ld + 8'd1;
    end
    past = page_w >= PAGE_LIMIT;
    draw = !stop_ld && !past;

    printable = (in_if.char_code >= FIRST_CODE) && (in_if.char_code <= LAST_CODE);
    code_adj  = printable ? (in_if.char_code - FIRST_CODE) : 8'h00;

    col_d  = col_q;
    page_d = page_q;
    stop_d = stop_q;
    if (xfer && !stop_ld) begin
      if (past) begin
        col_d  = col_w;
        page_d = page_w;
        stop_d = 1'b1;
      end else begin
        col_d  = col_w + GLYPH_ADV;
        page_d = page_w;
        stop_d = 1'b0;
      end
    end
  end

  assign q_push_o      = xfer && draw;
  assign q_job_o.page  = page_w[2:0];
  assign q_job_o.col   = col_w;
  assign q_job_o.glyph = code_adj[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= 8'h00;
      page_q <= 8'h00;
      stop_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      page_q <= page_d;
      stop_q <= stop_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tgr_queue.sv -----
// Short job queue between the front end and the byte sequencer.
`default_nettype none
module tgr_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire tgr_pkg::tgr_job_t job_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output tgr_pkg::tgr_job_t job_o,
  output logic              valid_o
);
  import tgr_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  tgr_job_t      mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == CNT_FULL;
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + AW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tgr_back.sv -----
// Back end: turns one queued job into nine registered output bytes.
`default_nettype none
module tgr_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire tgr_pkg::tgr_job_t job_i,
  input  wire logic         job_valid_i,
  output logic              pop_o,
  tgr_out_if.source         out_if
);
  import tgr_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              vld_q;
  logic              is_data_q, is_data_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;
  logic              load;
  logic [2:0]        gcol;
  logic [39:0]       row;

  assign load  = job_valid_i && (!vld_q || out_if.ready);
  assign pop_o = load && (step_q == STEP_LAST);

  assign gcol = 3'(step_q - STEP_GLYPH0);
  assign row  = glyph_row(job_i.glyph);

  always_comb begin
    is_data_d = 1'b1;
    last_d    = 1'b0;
    case (step_q)
      STEP_PAGE: begin
        is_data_d = 1'b0;
        byte_d    = CMD_PAGE_ADDR | {5'b0, job_i.page};
      end
      STEP_COL_LO: begin
        is_data_d = 1'b0;
        byte_d    = CMD_COL_LO | {4'b0, job_i.col[3:0]};
      end
      STEP_COL_HI: begin
        is_data_d = 1'b0;
        byte_d    = CMD_COL_HI | {4'b0, job_i.col[7:4]};
      end
      default: begin
        case (gcol)
          3'd0:    byte_d = row[39:32];
          3'd1:    byte_d = row[31:24];
          3'd2:    byte_d = row[23:16];
          3'd3:    byte_d = row[15:8];
          3'd4:    byte_d = row[7:0];
          default: byte_d = 8'h00;
        endcase
        last_d = step_q == STEP_LAST;
      end
    endcase
    step_d = (step_q == STEP_LAST) ? STEP_PAGE : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_data_q <= is_data_d;
      byte_q    <= byte_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_PAGE;
      vld_q  <= 1'b0;
    end else begin
      if (load) begin
        step_q <= step_d;
        vld_q  <= 1'b1;
      end else if (out_if.ready) begin
        vld_q  <= 1'b0;
      end
    end
  end

  assign out_if.valid        = vld_q;
  assign out_if.is_data      = is_data_q;
  assign out_if.out_byte     = byte_q;
  assign out_if.last_of_char = last_q;

endmodule
`default_nettype wire

// ----- hw/rtl/text_glyph_renderer.sv -----
// Top level of the 6x8 text glyph renderer for a page-addressed display.
//
// Usage:
//   in_if  : one character per transfer. start_of_text loads the cursor from
//            start_col/start_page and restarts a stopped string.
//   out_if : nine transfers per drawn character: page command, low column,
//            high column, then six glyph column bytes, the last one flagged
//            with last_of_char. Dropped characters (off the bottom or after a
//            stop) produce nothing.
//   Path:    with the queue and output empty, an accepted character is written
//            into the job queue, and its first byte is then loaded into the
//            output register, where it is valid to the receiver.
//   Throughput: one output byte per cycle while the receiver is ready and a job
//            is queued; the byte sequencer in the back end sets that rate. The
//            front end keeps accepting until the two-entry job queue is full.
//   Reset: cursor at column 0, page 0, not stopped; queue and output empty.
//   Stall: a stalled receiver holds the output register; the sequencer waits,
//            the queue fills, then in_if.ready drops.
`default_nettype none
module text_glyph_renderer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tgr_in_if.sink    in_if,
  tgr_out_if.source out_if
);
  import tgr_pkg::*;

  // front end to queue
  tgr_job_t push_job;
  logic     push;
  logic     q_full;

  // queue to back end
  tgr_job_t head_job;
  logic     head_valid;
  logic     pop;

  tgr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .q_full_i (q_full),
    .q_job_o  (push_job),
    .q_push_o (push)
  );

  tgr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (head_job),
    .valid_o (head_valid)
  );

  tgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (head_valid),
    .pop_o       (pop),
    .out_if      (out_if)
  );

  // A job is never pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // Popping a job coincides with loading its final glyph byte.
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_if.valid && out_if.last_of_char && out_if.is_data)
    else $error("job popped without its last byte");

  // The back end only pops a job that is present.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire
